FILE: hw/rtl/brcc_pkg.sv
// Shared constants, status codes and the CRC-32 byte step for the record checker.
package brcc_pkg;

    localparam int REC_LEN  = 16;
    localparam int CRC_SPAN = 12;
    localparam int POS_W    = 5;
    localparam int MAC_W    = 48;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [7:0]  CHAN_MAX = 8'd14;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_HEADER = 2'd1;
    localparam logic [1:0] STAT_CRC    = 2'd2;
    localparam logic [1:0] STAT_BIND   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MARKER   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND    = 8'd3;

    // Reflected CRC-32, one byte, eight bit steps.
    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic binding_valid(input logic [7:0] chan, input logic [MAC_W-1:0] mac);
        return (chan != 8'd0) && (chan <= CHAN_MAX) && !mac[MAC_W-8] && (mac != '0);
    endfunction

endpackage

FILE: hw/rtl/binding_record_crc_checker_core.sv
// Top level of the 16-byte binding record checker with CRC-32.
//
// Usage
//   Bytes arrive on the request channel (in_valid/in_ready, data_byte, first).
//   A byte with first set restarts a record as byte 0. Bytes 0..3 are compared
//   with the four configured header values, byte 11 must be zero, a reflected
//   CRC-32 over bytes 0..11 must match the little-endian word in bytes 12..15,
//   and the MAC (bytes 4..9) and channel (byte 10) must form a valid binding.
//   The 16th byte yields one result on the result channel (out_valid/out_ready):
//   accepted, status, lamp_mac and channel. Other bytes yield nothing; bytes
//   after the 16th are dropped until the next first.
//   A byte is taken into an input register and processed from there into the
//   record state; a record's result is shown by the output register.
//   Throughput: one byte per clock (the 16th of a record waits on a stalled
//   result), set by the eight-bit CRC step from input register to record state.
//   Reset: the record state goes idle (waiting for first), the configuration
//   registers clear to zero, and both valid flags drop.
//   Stall: a result waiting on out_ready holds only the byte that would make
//   the next result; bytes that produce no result keep flowing.
//   Configuration (cfg_we, cfg_index, cfg_data) is for the user to write while
//   idle (not enforced by the block); an index beyond the four registers is ignored.
module binding_record_crc_checker_core
    import brcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  first,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  accepted,
    output logic [1:0]            status,
    output logic [MAC_W-1:0]      lamp_mac,
    output logic [7:0]            channel
);

    // Configuration registers
    logic [7:0] marker_reg, format_reg, protocol_reg, bound_reg;

    // Input register
    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_first_reg;

    // Record state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    logic             hg_reg, hg_next;
    logic [31:0]      crc_rx_reg, crc_rx_next;
    logic [MAC_W-1:0] mac_reg, mac_next;
    logic [7:0]       chan_reg, chan_next;

    // Result register
    logic             out_valid_reg;
    logic             accepted_reg, accepted_next;
    logic [1:0]       status_reg, status_next;
    logic [MAC_W-1:0] mac_out_reg;
    logic [7:0]       chan_out_reg;

    // Record-restart view of the state for the byte in the input register
    logic [POS_W-1:0] pos_base;
    logic [31:0]      crc_base;
    logic             hg_base;
    logic [31:0]      crc_rx_base;
    logic [MAC_W-1:0] mac_base;
    logic [7:0]       chan_base;

    logic in_record;   // byte belongs to a live record
    logic last_byte;   // byte 15: produces a result
    logic proc_ok;     // stage may process this cycle
    logic proc;

    always_comb
    begin
        pos_base    = stg_first_reg ? '0 : pos_reg;
        crc_base    = stg_first_reg ? CRC_INIT : crc_reg;
        hg_base     = stg_first_reg ? 1'b1 : hg_reg;
        crc_rx_base = stg_first_reg ? 32'd0 : crc_rx_reg;
        mac_base    = stg_first_reg ? '0 : mac_reg;
        chan_base   = stg_first_reg ? 8'd0 : chan_reg;
    end

    assign in_record = pos_base < POS_W'(REC_LEN);
    assign last_byte = in_record && (pos_base == POS_W'(REC_LEN - 1));
    assign proc_ok   = !last_byte || !out_valid_reg || out_ready;
    assign proc      = stg_valid_reg && proc_ok;
    assign in_ready  = !stg_valid_reg || proc_ok;

    // Per-byte update of the record state
    always_comb
    begin
        pos_next    = pos_base;
        crc_next    = crc_base;
        hg_next     = hg_base;
        crc_rx_next = crc_rx_base;
        mac_next    = mac_base;
        chan_next   = chan_base;
        if (in_record)
        begin
            pos_next = pos_base + POS_W'(1);
            if (pos_base < POS_W'(CRC_SPAN))
            begin
                crc_next = crc32_byte(crc_base, stg_byte_reg);
            end
            case (pos_base)
                5'd0:  hg_next = hg_base && (stg_byte_reg == marker_reg);
                5'd1:  hg_next = hg_base && (stg_byte_reg == format_reg);
                5'd2:  hg_next = hg_base && (stg_byte_reg == protocol_reg);
                5'd3:  hg_next = hg_base && (stg_byte_reg == bound_reg);
                5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9:
                    mac_next = {mac_base[MAC_W-9:0], stg_byte_reg};
                5'd10: chan_next = stg_byte_reg;
                5'd11: hg_next = hg_base && (stg_byte_reg == 8'd0);
                default:
                begin
                    // CRC word, least significant byte first
                    case (pos_base[1:0])
                        2'd0:    crc_rx_next[7:0]   = stg_byte_reg;
                        2'd1:    crc_rx_next[15:8]  = stg_byte_reg;
                        2'd2:    crc_rx_next[23:16] = stg_byte_reg;
                        default: crc_rx_next[31:24] = stg_byte_reg;
                    endcase
                end
            endcase
        end
    end

    // Verdict, priority header/pad, then CRC, then binding
    always_comb
    begin
        if (!hg_next)
        begin
            status_next = STAT_HEADER;
        end
        else if ((crc_next ^ CRC_INIT) != crc_rx_next)
        begin
            status_next = STAT_CRC;
        end
        else if (!binding_valid(chan_next, mac_next))
        begin
            status_next = STAT_BIND;
        end
        else
        begin
            status_next = STAT_OK;
        end
        accepted_next = (status_next == STAT_OK);
    end

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg   <= 8'd0;
            format_reg   <= 8'd0;
            protocol_reg <= 8'd0;
            bound_reg    <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MARKER:   marker_reg   <= cfg_data;
                REG_FORMAT:   format_reg   <= cfg_data;
                REG_PROTOCOL: protocol_reg <= cfg_data;
                REG_BOUND:    bound_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Control: valid flags and record position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_W'(REC_LEN);
        end
        else
        begin
            if (in_ready)
            begin
                stg_valid_reg <= in_valid;
            end
            if (proc && last_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stg_byte_reg  <= data_byte;
            stg_first_reg <= first;
        end
        if (proc)
        begin
            crc_reg    <= crc_next;
            hg_reg     <= hg_next;
            crc_rx_reg <= crc_rx_next;
            mac_reg    <= mac_next;
            chan_reg   <= chan_next;
        end
        if (proc && last_byte)
        begin
            accepted_reg <= accepted_next;
            status_reg   <= status_next;
            mac_out_reg  <= mac_next;
            chan_out_reg <= chan_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign status    = status_reg;
    // Held apart from the record state, which moves on with the next record's bytes
    assign lamp_mac  = mac_out_reg;
    assign channel   = chan_out_reg;

endmodule

FILE: hw/rtl/brcc_checker.sv
// Port-level assertions for the record checker, bound to the top level.
module brcc_checker
    import brcc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  accepted,
    input logic [1:0]            status,
    input logic [MAC_W-1:0]      lamp_mac,
    input logic [7:0]            channel
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(accepted)
        && $stable(lamp_mac) && $stable(channel))
        else $error("result changed while stalled");

    a_acc_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> accepted == (status == STAT_OK))
        else $error("accepted disagrees with status");

    a_acc_binding: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> binding_valid(channel, lamp_mac))
        else $error("accepted record with invalid binding");

    a_bind_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_BIND) |-> !binding_valid(channel, lamp_mac))
        else $error("binding status on a valid binding");

endmodule

bind binding_record_crc_checker_core brcc_checker u_brcc_checker (.*);

FILE: sim/tb_binding_record_crc_checker_core.sv
// Self-checking testbench for the binding record checker: directed table, then random records.
module tb_binding_record_crc_checker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import brcc_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input is known from t=0.
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [7:0]           data_byte = '0;
    logic                 first     = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 accepted;
    logic [1:0]           status;
    logic [MAC_W-1:0]     lamp_mac;
    logic [7:0]           channel;

    always #1 clk = ~clk;

    binding_record_crc_checker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .first     (first),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .accepted  (accepted),
        .status    (status),
        .lamp_mac  (lamp_mac),
        .channel   (channel)
    );

    // One record verdict as it leaves the block.
    typedef struct packed {
        logic             acc;
        logic [1:0]       stat;
        logic [MAC_W-1:0] mac;
        logic [7:0]       chan;
    } verdict_t;

    // Directed table: where each byte comes from and how its outcome is judged.
    // SRC_CRC rows take the next little-endian CRC byte of the record so far.
    typedef enum logic [1:0] {SRC_LIT, SRC_CRC} byte_src_e;
    // CHK_NONE: no verdict may come; CHK_OK: a clean acceptance typed in below.
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_OK} row_chk_e;

    typedef struct packed {
        logic [7:0] b;
        logic       f;
        byte_src_e  src;
        row_chk_e   chk;
    } dir_row_t;

    // Faults that the random record builder can plant, used as mask bit positions.
    typedef enum int {F_HDR, F_PAD, F_CHAN, F_MCAST, F_MACZERO, F_CRC} fault_e;

    localparam int DIR_ROWS = 24;

    // Reset config is all zeros, so header bytes of 00 are correct here.
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // idle after reset: bytes without first are dropped
        '{8'hFF, 1'b0, SRC_LIT, CHK_NONE},
        '{8'h00, 1'b0, SRC_LIT, CHK_NONE},
        // partial record with a bad format byte, abandoned by a restart
        '{8'h00, 1'b1, SRC_LIT, CHK_PREDICT},
        '{8'hFF, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'hFF, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h00, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h01, 1'b0, SRC_LIT, CHK_PREDICT},
        // clean record, channel at the top of its range
        '{8'h00, 1'b1, SRC_LIT, CHK_PREDICT},
        '{8'h00, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h00, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h00, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h02, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h11, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h22, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h33, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h44, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h55, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h0E, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h00, 1'b0, SRC_LIT, CHK_PREDICT},
        '{8'h00, 1'b0, SRC_CRC, CHK_PREDICT},
        '{8'h00, 1'b0, SRC_CRC, CHK_PREDICT},
        '{8'h00, 1'b0, SRC_CRC, CHK_PREDICT},
        '{8'h00, 1'b0, SRC_CRC, CHK_OK},
        // byte after a finished record: dropped
        '{8'h5A, 1'b0, SRC_LIT, CHK_NONE}
    };

    localparam verdict_t CLEAN_VERDICT = '{1'b1, STAT_OK, 48'h02_1122_3344_55, 8'd14};

    // ------------------------------------------------------------------
    // Shadow of the block: header registers and the record in progress.
    // ------------------------------------------------------------------
    logic [7:0]       hdr_cfg [4];
    int unsigned      rec_pos;
    logic [31:0]      rec_crc;
    logic             hdr_ok;
    logic [31:0]      crc_rx;
    logic [MAC_W-1:0] mac_acc;
    logic [7:0]       chan_acc;

    verdict_t    verdict_q [$];
    int unsigned fails;
    int unsigned bytes_taken;     // bytes that entered a record (dropped ones excluded)
    int unsigned verdicts_made;

    // Sender burst shaping and the one long stall requested of the receiver.
    int unsigned burst_left;
    bit          hold_off_req;

    logic [7:0] rec_buf [16];

    // Reflected CRC-32, feeding the data bit in at the LSB on each shift.
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r  = (r >> 1) ^ (fb ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    // Advance the shadow record by one byte; done marks the 16th byte.
    task automatic absorb_byte(input logic [7:0] b, input logic f,
                               output bit used, output bit done, output verdict_t v);
        logic [31:0] crc_calc;
        logic        bind_ok;
        used = 1'b0;
        done = 1'b0;
        v    = '0;
        if (f)
        begin
            rec_pos  = 0;
            rec_crc  = CRC_INIT;
            hdr_ok   = 1'b1;
            crc_rx   = '0;
            mac_acc  = '0;
            chan_acc = '0;
        end
        if (rec_pos >= REC_LEN)
            return;
        used = 1'b1;
        if (rec_pos < CRC_SPAN)
            rec_crc = crc_step(rec_crc, b);
        if (rec_pos < 4)
        begin
            if (b != hdr_cfg[rec_pos])
                hdr_ok = 1'b0;
        end
        else if (rec_pos < 10)
            mac_acc = {mac_acc[MAC_W-9:0], b};
        else if (rec_pos == 10)
            chan_acc = b;
        else if (rec_pos == 11)
        begin
            if (b != 8'd0)
                hdr_ok = 1'b0;
        end
        else
            crc_rx[8*(rec_pos-12) +: 8] = b;
        rec_pos++;
        if (rec_pos != REC_LEN)
            return;

        crc_calc = rec_crc ^ CRC_INIT;
        bind_ok  = (chan_acc >= 8'd1) && (chan_acc <= CHAN_MAX)
                   && (mac_acc[40] == 1'b0) && (mac_acc != '0);
        done   = 1'b1;
        v.mac  = mac_acc;
        v.chan = chan_acc;
        // priority: header/pad, then CRC, then binding
        if (!hdr_ok)
            v.stat = STAT_HEADER;
        else if (crc_calc != crc_rx)
            v.stat = STAT_CRC;
        else if (!bind_ok)
            v.stat = STAT_BIND;
        else
            v.stat = STAT_OK;
        v.acc = (v.stat == STAT_OK);
    endtask

    // ------------------------------------------------------------------
    // Configuration. Callers hold in_valid low and wait for the queue to
    // empty first. cfg_we stays high across back-to-back writes.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            REG_MARKER:   hdr_cfg[0] = v;
            REG_FORMAT:   hdr_cfg[1] = v;
            REG_PROTOCOL: hdr_cfg[2] = v;
            REG_BOUND:    hdr_cfg[3] = v;
            default:      ;   // out of range: block ignores it
        endcase
    endtask

    task automatic set_header(input logic [7:0] m, input logic [7:0] fv,
                              input logic [7:0] p, input logic [7:0] bf);
        write_reg(REG_MARKER, m);
        write_reg(REG_FORMAT, fv);
        write_reg(REG_PROTOCOL, p);
        // stray write past the last register, then the real bound flag
        write_reg(REG_BOUND + 8'($urandom_range(1, 252)), 8'($urandom));
        write_reg(REG_BOUND, bf);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Request side. Bursts of random length separated by random gaps;
    // valid is only dropped when a gap actually starts.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic f,
                             output bit done, output verdict_t v);
        bit used;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        first     <= f;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_byte(b, f, used, done, v);
        if (used)
            bytes_taken++;
    endtask

    task automatic feed(input logic [7:0] b, input logic f);
        bit       done;
        verdict_t v;
        send_byte(b, f, done, v);
        if (done)
        begin
            verdict_q.push_back(v);
            verdicts_made++;
        end
    endtask

    // Sender pause: wait until every verdict is back, then let the pipe settle
    // (input reg, process stage, output reg) before touching the registers.
    task automatic drain();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Build one 16-byte record against the current header, planting faults.
    task automatic make_record();
        int          mode;
        int          k;
        logic [5:0]  faults;
        logic [31:0] c;
        for (int i = 0; i < 4; i++)
            rec_buf[i] = hdr_cfg[i];
        for (int i = 4; i < 10; i++)
            rec_buf[i] = 8'($urandom);
        rec_buf[4][0] = 1'b0;
        rec_buf[10]   = 8'($urandom_range(1, 14));
        rec_buf[11]   = 8'd0;

        // MAC and channel extremes now and then
        case ($urandom_range(0, 9))
            0:
            begin
                rec_buf[4] = 8'hFE;
                for (int i = 5; i < 10; i++)
                    rec_buf[i] = 8'hFF;
                rec_buf[10] = 8'd1;
            end
            1:
            begin
                for (int i = 4; i < 9; i++)
                    rec_buf[i] = 8'h00;
                rec_buf[9]  = 8'h01;
                rec_buf[10] = CHAN_MAX;
            end
            default: ;
        endcase

        // half clean, three in ten single faults, the rest mixed to exercise priority
        mode = $urandom_range(0, 19);
        if (mode < 10)
            faults = '0;
        else if (mode < 16)
            faults = 6'b1 << $urandom_range(0, F_CRC);
        else
            faults = 6'($urandom_range(1, 63));

        if (faults[F_HDR])
        begin
            k = $urandom_range(0, 3);
            rec_buf[k] = rec_buf[k] ^ 8'($urandom_range(1, 255));
        end
        if (faults[F_PAD])
            rec_buf[11] = 8'($urandom_range(1, 255));
        if (faults[F_CHAN])
        begin
            case ($urandom_range(0, 3))
                0:       rec_buf[10] = 8'd0;
                1:       rec_buf[10] = CHAN_MAX + 8'd1;
                2:       rec_buf[10] = 8'hFF;
                default: rec_buf[10] = 8'($urandom_range(15, 255));
            endcase
        end
        if (faults[F_MCAST])
            rec_buf[4][0] = 1'b1;
        if (faults[F_MACZERO])
            for (int i = 4; i < 10; i++)
                rec_buf[i] = 8'h00;

        c = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++)
            c = crc_step(c, rec_buf[i]);
        c = c ^ CRC_INIT;
        for (int i = 0; i < 4; i++)
            rec_buf[CRC_SPAN+i] = c[8*i +: 8];
        if (faults[F_CRC])
        begin
            k = CRC_SPAN + $urandom_range(0, 3);
            rec_buf[k][$urandom_range(0, 7)] = ~rec_buf[k][$urandom_range(0, 7)];
            rec_buf[k] = rec_buf[k] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    // One unit of random traffic: optional idle noise, optional abandoned
    // partial record, then a full record.
    task automatic random_record();
        int n;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) feed(8'($urandom), 1'b0);
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 15);
            feed(8'($urandom), 1'b1);
            repeat (n - 1) feed(8'($urandom), 1'b0);
        end
        make_record();
        feed(rec_buf[0], 1'b1);
        for (int i = 1; i < REC_LEN; i++)
            feed(rec_buf[i], 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Result side. Ready follows a pattern that is re-chosen at random; once
    // asked, it holds off so that the block backs up.
    // ------------------------------------------------------------------
    int unsigned rx_cyc    = 0;
    int unsigned rx_mode   = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    logic        rx_next;

    always @(posedge clk)
    begin
        rx_cyc++;
        if (rx_cyc % 50 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_left != 0)
        begin
            hold_left--;
            rx_next = 1'b0;
        end
        else if (hold_off_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = 300;
            rx_next   = 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       rx_next = 1'b1;
                1:       rx_next = 1'($urandom_range(0, 1));
                2:       rx_next = ($urandom_range(0, 3) == 0);
                default: rx_next = ((rx_cyc / 3) % 2 == 0);
            endcase
        end
        out_ready <= rx_next;
    end

    // Compare each handed-over verdict with the oldest one owed.
    verdict_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("verdict with none pending: accepted=%0d status=%0d", accepted, status);
                fails++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (accepted !== want.acc)
                begin
                    $error("accepted: expected %0d, got %0d", want.acc, accepted);
                    fails++;
                end
                if (status !== want.stat)
                begin
                    $error("status: expected %0d, got %0d", want.stat, status);
                    fails++;
                end
                if (lamp_mac !== want.mac)
                begin
                    $error("lamp_mac: expected %h, got %h", want.mac, lamp_mac);
                    fails++;
                end
                if (channel !== want.chan)
                begin
                    $error("channel: expected %0d, got %0d", want.chan, channel);
                    fails++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t    row;
        logic [7:0]  b;
        bit          done;
        verdict_t    v;
        int unsigned taken0;
        int unsigned made0;
        int unsigned lim;

        fails         = 0;
        bytes_taken   = 0;
        verdicts_made = 0;
        burst_left    = 0;
        hold_off_req  = 1'b0;
        for (int i = 0; i < 4; i++)
            hdr_cfg[i] = 8'd0;
        rec_pos = REC_LEN;      // idle until a first byte
        rec_crc = CRC_INIT;
        hdr_ok  = 1'b1;
        crc_rx  = '0;
        mac_acc = '0;
        chan_acc = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows with the reset header (all zero).
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = DIR_TAB[r];
            b   = row.b;
            if (row.src == SRC_CRC)
                b = 8'((rec_crc ^ CRC_INIT) >> (8 * (rec_pos - CRC_SPAN)));
            send_byte(b, row.f, done, v);
            case (row.chk)
                CHK_PREDICT:
                    if (done)
                        verdict_q.push_back(v);
                CHK_OK:
                    verdict_q.push_back(CLEAN_VERDICT);
                default: ;
            endcase
        end
        drain();

        // Random phases, each under its own header setting.
        for (int ph = 1; ph <= 4; ph++)
        begin
            case (ph)
                1:       set_header(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                3:       set_header(8'h00, 8'hFF, 8'h00, 8'hFF);
                default: set_header(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            // long receiver hold-off while requests keep coming
            if (ph == 2)
                hold_off_req = 1'b1;
            taken0 = bytes_taken;
            made0  = verdicts_made;
            while (bytes_taken - taken0 < 110 || verdicts_made - made0 < 9)
                random_record();
            drain();
        end

        lim = 0;
        while (verdict_q.size() != 0 && lim < 5000)
        begin
            @(posedge clk);
            lim++;
        end
        repeat (10) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $error("%0d verdicts never arrived", verdict_q.size());
            fails++;
        end

        if (fails == 0)
            $display("[binding_record_crc_checker_core] OK");
        else
            $display("[binding_record_crc_checker_core] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("[binding_record_crc_checker_core] ERROR");
        $finish;
    end

endmodule
